// File: sv/aob_pkg.sv
package aob_pkg;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned PixW   = 4 * ChanW;
  localparam int unsigned WgtW   = 2 * ChanW;
  localparam int unsigned NumW   = 3 * ChanW;
  localparam int unsigned NumCh  = 3;
  localparam int unsigned QStages = ChanW;
  localparam int unsigned Latency = QStages + 2;
  localparam logic [ChanW-1:0] ChanMax = '1;

  typedef logic [NumW-1:0] num_t;
  typedef logic [ChanW-1:0] chan_t;
endpackage

// File: sv/alpha_over_blender.sv
// source-over compositing of straight-alpha RGBA8 pixels (red in the top byte)
//
// input: pulse start_i with src_pixel_i and dst_pixel_i; the item is taken at
// that edge. busy_o is always low, so a new pixel pair may enter every cycle.
// output: valid_o is high for exactly one cycle with out_pixel_o; there is no
// backpressure, the receiver takes the item in that cycle.
//
// throughput is one pixel per clock.
// the first two stages form the weights and numerators (one multiply level
// each); eight more stages each retire one quotient bit of the per-channel
// division, restoring style. output alpha is floor(D/255) by a reciprocal
// trick. when both alphas are zero the pixel comes out as all zero.
//
// reset (rst_ni low, asynchronous) clears the valid bits of every stage;
// items in flight are dropped and no result appears until a new start_i.
module alpha_over_blender (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [aob_pkg::PixW-1:0] src_pixel_i,
  input  logic [aob_pkg::PixW-1:0] dst_pixel_i,
  output logic                     valid_o,
  output logic [aob_pkg::PixW-1:0] out_pixel_o
);
  import aob_pkg::*;

  // stage a: weights
  logic                vld_a_q;
  logic [WgtW-1:0]     ws_a_q, wd_a_q;
  logic [PixW-1:0]     src_a_q, dst_a_q;

  // stage b: numerators, denominator, alpha
  logic                vld_b_q, zero_b_q;
  logic [WgtW-1:0]     den_b_q;
  chan_t               alpha_b_q;
  num_t                num_b_q [NumCh];

  // quotient stages
  logic                vld_s_q  [QStages];
  logic                zero_s_q [QStages];
  logic [WgtW-1:0]     den_s_q  [QStages];
  chan_t               alpha_s_q[QStages];
  num_t                rem_s_q  [QStages][NumCh];
  chan_t               quo_s_q  [QStages][NumCh];

  logic [WgtW-1:0]     den_sum;
  logic [WgtW:0]       alpha_tmp;

  assign busy_o = 1'b0;

  always_comb begin
    den_sum   = ws_a_q + wd_a_q;
    alpha_tmp = {1'b0, den_sum} + (WgtW+1)'(1) + (WgtW+1)'(den_sum >> ChanW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      for (int k = 0; k < QStages; k++) vld_s_q[k] <= 1'b0;
    end else begin
      vld_a_q <= start_i;
      vld_b_q <= vld_a_q;
      vld_s_q[0] <= vld_b_q;
      for (int k = 1; k < QStages; k++) vld_s_q[k] <= vld_s_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    // as*255 is a shift and subtract
    ws_a_q  <= {src_pixel_i[ChanW-1:0], ChanW'(0)} - WgtW'(src_pixel_i[ChanW-1:0]);
    wd_a_q  <= dst_pixel_i[ChanW-1:0] * WgtW'(ChanMax - src_pixel_i[ChanW-1:0]);
    src_a_q <= src_pixel_i;
    dst_a_q <= dst_pixel_i;

    den_b_q   <= den_sum;
    zero_b_q  <= (den_sum == '0);
    alpha_b_q <= alpha_tmp[WgtW-1:ChanW];
    for (int c = 0; c < NumCh; c++) begin
      num_b_q[c] <= NumW'(src_a_q[(c+1)*ChanW +: ChanW]) * NumW'(ws_a_q)
                  + NumW'(dst_a_q[(c+1)*ChanW +: ChanW]) * NumW'(wd_a_q);
    end

    // one quotient bit per stage, msb first
    for (int k = 0; k < QStages; k++) begin
      if (k == 0) begin
        den_s_q[0]   <= den_b_q;
        zero_s_q[0]  <= zero_b_q;
        alpha_s_q[0] <= alpha_b_q;
      end else begin
        den_s_q[k]   <= den_s_q[k-1];
        zero_s_q[k]  <= zero_s_q[k-1];
        alpha_s_q[k] <= alpha_s_q[k-1];
      end
    end
    for (int c = 0; c < NumCh; c++) begin
      if (num_b_q[c] >= (NumW'(den_b_q) << (QStages-1))) begin
        rem_s_q[0][c] <= num_b_q[c] - (NumW'(den_b_q) << (QStages-1));
        quo_s_q[0][c] <= ChanW'(1);
      end else begin
        rem_s_q[0][c] <= num_b_q[c];
        quo_s_q[0][c] <= '0;
      end
      for (int k = 1; k < QStages; k++) begin
        if (rem_s_q[k-1][c] >= (NumW'(den_s_q[k-1]) << (QStages-1-k))) begin
          rem_s_q[k][c] <= rem_s_q[k-1][c] - (NumW'(den_s_q[k-1]) << (QStages-1-k));
          quo_s_q[k][c] <= {quo_s_q[k-1][c][ChanW-2:0], 1'b1};
        end else begin
          rem_s_q[k][c] <= rem_s_q[k-1][c];
          quo_s_q[k][c] <= {quo_s_q[k-1][c][ChanW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_s_q[QStages-1];
  assign out_pixel_o = zero_s_q[QStages-1] ? '0 :
      {quo_s_q[QStages-1][2], quo_s_q[QStages-1][1], quo_s_q[QStages-1][0],
       alpha_s_q[QStages-1]};

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(Latency) valid_o)
    else $error("result missing after start");

  a_zero_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (out_pixel_o[ChanW-1:0] == '0) |-> (out_pixel_o == '0))
    else $error("transparent result with color");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !zero_s_q[QStages-1] |->
      (rem_s_q[QStages-1][0] < NumW'(den_s_q[QStages-1])))
    else $error("division remainder out of range");
endmodule
